[rtl/rse_pkg.sv]
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, constants and field helpers for the Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

    // Low byte of the field polynomial x^8 + x^4 + x^3 + x^2 + 1
    localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;

    localparam int DEF_MAX_DEGREE = 30;
    localparam int RESET_DEGREE   = 15;
    localparam int CFG_W          = 5;

    // Operations on one tap line
    typedef enum logic [2:0] {
        LINE_HOLD,
        LINE_CLEAR,
        LINE_SEED,
        LINE_PUSH,
        LINE_DRAIN
    } t_line_op;

    typedef struct packed {
        t_line_op   op;
        logic [7:0] data;
    } t_line_ctl;

    typedef enum logic [2:0] {
        ST_SEED,
        ST_BUILD,
        ST_IDLE,
        ST_ENCODE,
        ST_EMIT
    } t_state;

    // Multiply by alpha (0x02) in GF(256)
    function automatic logic [7:0] gf_mul_alpha(input logic [7:0] a);
        gf_mul_alpha = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY_LOW : 8'h00);
    endfunction

endpackage

[rtl/rse_gf_mul.sv]
// ----------------------------------------------------------------------------
// rse_gf_mul
// GF(256) multiplier, polynomial 0x11D, shift-and-add over the eight bits.
// ----------------------------------------------------------------------------
module rse_gf_mul (
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    output logic [7:0] o_p
);

    always_comb begin
        logic [7:0] acc;
        acc = 8'h00;
        for (int bit_idx = 7; bit_idx >= 0; bit_idx--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? rse_pkg::FIELD_POLY_LOW : 8'h00);
            if (i_b[bit_idx]) begin
                acc = acc ^ i_a;
            end
        end
        o_p = acc;
    end

endmodule

[rtl/rse_tap_line.sv]
// ----------------------------------------------------------------------------
// rse_tap_line
// Byte shift line read at its two lowest taps; a push shifts down and loads
// the entry at degree-1, a drain shifts down and fills zeros at the top.
// ----------------------------------------------------------------------------
module rse_tap_line #(
    parameter int MAX_DEGREE = rse_pkg::DEF_MAX_DEGREE,
    parameter int DW         = $clog2(MAX_DEGREE + 1)
) (
    input  logic               i_clk,
    input  logic [DW-1:0]      i_degree,
    input  rse_pkg::t_line_ctl i_ctl,
    output logic [7:0]         o_tap0,
    output logic [7:0]         o_tap1
);

    logic [7:0]    r_taps [MAX_DEGREE];
    logic [7:0]    n_taps [MAX_DEGREE];
    logic [DW-1:0] top_idx;

    assign top_idx = DW'(i_degree - 1'b1);

    always_comb begin
        for (int j = 0; j < MAX_DEGREE; j++) begin
            unique case (i_ctl.op)
                rse_pkg::LINE_CLEAR: n_taps[j] = 8'h00;
                rse_pkg::LINE_SEED:  n_taps[j] = (DW'(j) == top_idx) ? 8'h01 : 8'h00;
                rse_pkg::LINE_PUSH: begin
                    if (DW'(j) == top_idx) begin
                        n_taps[j] = i_ctl.data;
                    end else if (j < MAX_DEGREE - 1) begin
                        n_taps[j] = r_taps[(j < MAX_DEGREE - 1) ? j + 1 : j];
                    end else begin
                        n_taps[j] = 8'h00;
                    end
                end
                rse_pkg::LINE_DRAIN: begin
                    n_taps[j] = (j < MAX_DEGREE - 1) ?
                                r_taps[(j < MAX_DEGREE - 1) ? j + 1 : j] : 8'h00;
                end
                default: n_taps[j] = r_taps[j];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_taps <= n_taps;
    end

    assign o_tap0 = r_taps[0];
    assign o_tap1 = r_taps[1];

endmodule

[rtl/reed_solomon_ecc_encoder.sv]
// ----------------------------------------------------------------------------
// reed_solomon_ecc_encoder
// Systematic RS parity generator over GF(256), polynomial 0x11D, roots
// alpha^0..alpha^(d-1), built around one shared GF multiplier.
// ----------------------------------------------------------------------------
// Input: each data byte steps through every generator tap in the shared
//   multiplier, and the next byte is taken only once the block is idle again.
// Output: once the last data byte of a block has been through the encoder,
//   d parity bytes are offered, one per output transfer.
// Reset (i_rst_n, synchronous): degree returns to 15 (or MAX_DEGREE if less);
//   the generator is rebuilt (seed, then build) with both ports stalled. A
//   degree write triggers the same rebuild and clears the remainder.
// ----------------------------------------------------------------------------
module reed_solomon_ecc_encoder #(
    parameter int MAX_DEGREE = rse_pkg::DEF_MAX_DEGREE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: parity_degree
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data,     // [4:0] parity_degree
    // data in
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // block_end
    // parity out
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] parity_byte
    output logic       m_axis_tlast    // parity_last
);

    localparam int DW        = $clog2(MAX_DEGREE + 1);
    localparam int CW        = (DW > rse_pkg::CFG_W) ? DW : rse_pkg::CFG_W;
    localparam int RESET_DEG = (rse_pkg::RESET_DEGREE > MAX_DEGREE) ?
                               MAX_DEGREE : rse_pkg::RESET_DEGREE;

    rse_pkg::t_state    r_state, n_state;
    logic [DW-1:0]      r_degree;
    logic [DW-1:0]      r_k;         // tap step within a pass
    logic [DW-1:0]      r_i;         // root index while building
    logic [7:0]         r_root;
    logic [7:0]         r_factor;
    logic               r_last;

    logic [DW-1:0]      deg_m1;
    logic               k_end;
    logic [CW-1:0]      cfg_ext;
    logic [DW-1:0]      cfg_deg;
    logic               cfg_xfer;
    logic               in_xfer;
    logic               out_xfer;

    logic [7:0]         gen_tap0, gen_tap1;
    logic [7:0]         rem_tap0, rem_tap1;
    logic [7:0]         mul_b, mul_p;
    rse_pkg::t_line_ctl gen_ctl, rem_ctl;

    assign deg_m1   = DW'(r_degree - 1'b1);
    assign k_end    = (r_k == deg_m1);
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Clamp the written degree into 1..MAX_DEGREE
    assign cfg_ext = CW'(i_cfg_data);
    always_comb begin
        priority if (cfg_ext == '0) begin
            cfg_deg = DW'(1);
        end else if (cfg_ext > CW'(MAX_DEGREE)) begin
            cfg_deg = DW'(MAX_DEGREE);
        end else begin
            cfg_deg = DW'(cfg_ext);
        end
    end

    // Shared multiplier: generator tap times the feedback factor when
    // encoding, times the current root when building the generator
    assign mul_b = (r_state == rse_pkg::ST_ENCODE) ? r_factor : r_root;

    rse_gf_mul u_mul (
        .i_a (gen_tap0),
        .i_b (mul_b),
        .o_p (mul_p)
    );

    rse_tap_line #(
        .MAX_DEGREE (MAX_DEGREE),
        .DW         (DW)
    ) u_gen_line (
        .i_clk    (i_clk),
        .i_degree (r_degree),
        .i_ctl    (gen_ctl),
        .o_tap0   (gen_tap0),
        .o_tap1   (gen_tap1)
    );

    rse_tap_line #(
        .MAX_DEGREE (MAX_DEGREE),
        .DW         (DW)
    ) u_rem_line (
        .i_clk    (i_clk),
        .i_degree (r_degree),
        .i_ctl    (rem_ctl),
        .o_tap0   (rem_tap0),
        .o_tap1   (rem_tap1)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rse_pkg::ST_SEED:  n_state = rse_pkg::ST_BUILD;
            rse_pkg::ST_BUILD: begin
                if (k_end && (r_i == deg_m1)) begin
                    n_state = rse_pkg::ST_IDLE;
                end
            end
            rse_pkg::ST_IDLE: begin
                if (cfg_xfer) begin
                    n_state = rse_pkg::ST_SEED;
                end else if (in_xfer) begin
                    n_state = rse_pkg::ST_ENCODE;
                end
            end
            rse_pkg::ST_ENCODE: begin
                if (k_end) begin
                    n_state = r_last ? rse_pkg::ST_EMIT : rse_pkg::ST_IDLE;
                end
            end
            rse_pkg::ST_EMIT: begin
                if (out_xfer && k_end) begin
                    n_state = rse_pkg::ST_IDLE;
                end
            end
            default: n_state = rse_pkg::ST_SEED;
        endcase
    end

    // Outputs and tap line control
    always_comb begin
        o_cfg_ready   = 1'b0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        gen_ctl       = '{op: rse_pkg::LINE_HOLD, data: 8'h00};
        rem_ctl       = '{op: rse_pkg::LINE_HOLD, data: 8'h00};
        unique case (r_state)
            rse_pkg::ST_SEED: begin
                // g(x) = 1, remainder empty
                gen_ctl.op = rse_pkg::LINE_SEED;
                rem_ctl.op = rse_pkg::LINE_CLEAR;
            end
            rse_pkg::ST_BUILD: begin
                // g[k] = g[k]*root ^ g[k+1] (old), top term has no neighbor
                gen_ctl.op   = rse_pkg::LINE_PUSH;
                gen_ctl.data = (k_end ? 8'h00 : gen_tap1) ^ mul_p;
            end
            rse_pkg::ST_IDLE: begin
                o_cfg_ready   = 1'b1;
                // config wins a tie so the degree and data never land together
                s_axis_tready = !i_cfg_valid;
            end
            rse_pkg::ST_ENCODE: begin
                // rem[k] = rem[k+1] ^ g[k]*factor; rotate the generator
                rem_ctl.op   = rse_pkg::LINE_PUSH;
                rem_ctl.data = (k_end ? 8'h00 : rem_tap1) ^ mul_p;
                gen_ctl.op   = rse_pkg::LINE_PUSH;
                gen_ctl.data = gen_tap0;
            end
            rse_pkg::ST_EMIT: begin
                m_axis_tvalid = 1'b1;
                // drain shifts zeros in, leaving the remainder clear at the end
                if (m_axis_tready) begin
                    rem_ctl.op = rse_pkg::LINE_DRAIN;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tdata = rem_tap0;
    assign m_axis_tlast = k_end;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rse_pkg::ST_SEED;
            r_degree <= DW'(RESET_DEG);
            r_k      <= '0;
            r_i      <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                rse_pkg::ST_SEED: begin
                    r_k <= '0;
                    r_i <= '0;
                end
                rse_pkg::ST_BUILD: begin
                    if (k_end) begin
                        r_k <= '0;
                        r_i <= DW'(r_i + 1'b1);
                    end else begin
                        r_k <= DW'(r_k + 1'b1);
                    end
                end
                rse_pkg::ST_IDLE: begin
                    r_k <= '0;
                    if (cfg_xfer) begin
                        r_degree <= cfg_deg;
                    end
                end
                rse_pkg::ST_ENCODE: r_k <= k_end ? '0 : DW'(r_k + 1'b1);
                rse_pkg::ST_EMIT: begin
                    if (out_xfer) begin
                        r_k <= k_end ? '0 : DW'(r_k + 1'b1);
                    end
                end
                default: r_k <= '0;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == rse_pkg::ST_SEED) begin
            r_root <= 8'h01;
        end else if ((r_state == rse_pkg::ST_BUILD) && k_end) begin
            r_root <= rse_pkg::gf_mul_alpha(r_root);
        end
        if (in_xfer) begin
            r_factor <= s_axis_tdata ^ rem_tap0;
            r_last   <= s_axis_tlast;
        end
    end

`ifndef SYNTH
    // Input and output never open together
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while parity is pending");

    // Final parity transfer returns the block to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> o_cfg_ready)
        else $error("block not idle after last parity");

    // Degree stays within 1..MAX_DEGREE
    a_degree_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_degree != '0) && (r_degree <= DW'(MAX_DEGREE)))
        else $error("parity degree out of range");

    // Step counter never passes the degree while working
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rse_pkg::ST_ENCODE || r_state == rse_pkg::ST_EMIT ||
         r_state == rse_pkg::ST_BUILD) |-> (r_k < r_degree))
        else $error("step counter beyond degree");

    // A degree write always restarts the generator build
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_state == rse_pkg::ST_SEED))
        else $error("degree write did not rebuild generator");
`endif

endmodule

[verif/reed_solomon_ecc_encoder_tb.sv]
// ----------------------------------------------------------------------------
// reed_solomon_ecc_encoder_tb
// Self-checking bench for the RS(GF256, 0x11D) parity generator. A directed
// vector list walks the degree extremes, the clamping of degree 0 and 31,
// and a degree write that lands in the middle of a block. Random blocks at
// random degrees follow. An in-bench encoder predicts each parity byte not
// fixed by a vector, and the checker compares each transfer against it in order.
// ----------------------------------------------------------------------------
module reed_solomon_ecc_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXD             = rse_pkg::DEF_MAX_DEGREE;
    localparam int ITEMS            = 500;
    localparam int IDLE_PCT         = 8;
    localparam int SINK_HOLD_CYCLES = 400;
    // Covers a non-last byte still in flight at the largest degree
    localparam int SETTLE_CYCLES    = MAXD + 10;
    // Longest quiet period: generator rebuild plus the sink hold-off
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int NUM_VECS         = 19;

    typedef struct packed {
        logic [7:0] parity;
        logic       last;
    } t_parity;

    // One directed vector; parity_fixed is a hand-derived value for every
    // parity byte of the block, used instead of the encoder model when fixed is set.
    typedef struct packed {
        logic                      cfg_en;
        logic [rse_pkg::CFG_W-1:0] cfg_val;
        logic [7:0]                data;
        logic                      last;
        logic                      fixed;
        logic [7:0]                parity_fixed;
    } t_vec;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                      i_cfg_valid   = 1'b0;
    logic [rse_pkg::CFG_W-1:0] i_cfg_data    = '0;
    logic                      o_cfg_ready;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = '0;
    logic                      s_axis_tlast  = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [7:0]                m_axis_tdata;
    logic                      m_axis_tlast;

    // Encoder model state
    logic [7:0] rem_q [MAXD];
    logic [7:0] gen_q [MAXD];
    int         deg_q;

    t_parity parity_q [$];

    // Run control shared by the stimulus and sink processes
    logic steady         = 1'b0;   // suppress random idling on both sides
    int   sink_hold_asks = 0;      // bumped by stimulus to request a hold-off
    int   sink_hold_done = 0;

    int fail_cnt   = 0;
    int stall_cnt  = 0;
    int byte_cnt   = 0;
    int block_cnt  = 0;
    int parity_cnt = 0;
    int cfg_cnt    = 0;

    t_vec vecs [NUM_VECS];

    reed_solomon_ecc_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),      // [4:0] parity_degree
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] data_byte
        .s_axis_tlast  (s_axis_tlast),    // block_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [7:0] parity_byte
        .m_axis_tlast  (m_axis_tlast)     // parity_last
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------

    // GF(256) product, MSB-first shift-and-add reduced by x^8+x^4+x^3+x^2+1
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int bit_i = 7; bit_i >= 0; bit_i--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? rse_pkg::FIELD_POLY_LOW : 8'h00);
            if (b[bit_i]) acc ^= a;
        end
        return acc;
    endfunction

    // Clamp the degree, rebuild g(x) = prod (x - a^i), clear the remainder
    task automatic load_degree(input logic [rse_pkg::CFG_W-1:0] v);
        logic [7:0] root;
        deg_q = (v == 0) ? 1 : ((v > MAXD) ? MAXD : int'(v));
        for (int i = 0; i < MAXD; i++) begin
            rem_q[i] = 8'h00;
            gen_q[i] = 8'h00;
        end
        gen_q[deg_q-1] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < deg_q; i++) begin
            for (int j = 0; j < deg_q; j++) begin
                gen_q[j] = gf_times(gen_q[j], root);
                if (j + 1 < deg_q) gen_q[j] ^= gen_q[j+1];
            end
            root = gf_times(root, 8'h02);
        end
    endtask

    // Absorb one data byte; on block end, queue the parity bytes MSB first
    task automatic encode_byte(input logic [7:0] b, input logic l,
                               input logic fixed, input logic [7:0] parity_fixed);
        logic [7:0] fb;
        t_parity    item;
        fb = b ^ rem_q[0];
        for (int i = 0; i + 1 < deg_q; i++) rem_q[i] = rem_q[i+1] ^ gf_times(gen_q[i], fb);
        rem_q[deg_q-1] = gf_times(gen_q[deg_q-1], fb);
        if (l) begin
            for (int i = 0; i < deg_q; i++) begin
                item.parity = fixed ? parity_fixed : rem_q[i];
                item.last   = (i == deg_q - 1);
                parity_q.push_back(item);
            end
            for (int i = 0; i < MAXD; i++) rem_q[i] = 8'h00;
            block_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    task automatic wait_drained();
        while (parity_q.size() != 0) @(posedge i_clk);
    endtask

    // Write the degree only once the encoder is quiet; a trailing non-last
    // byte gives no parity, so allow it time to finish in the multiplier.
    // Drop the data side first so the last byte is not taken twice.
    task automatic write_degree(input logic [rse_pkg::CFG_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        load_degree(v);
        cfg_cnt++;
    endtask

    // Offer one byte; keep tvalid high across back-to-back transfers
    task automatic push_byte(input logic [7:0] b, input logic l,
                             input logic fixed, input logic [7:0] parity_fixed);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
        encode_byte(b, l, fixed, parity_fixed);
        byte_cnt++;
    endtask

    // Sink: random backpressure, plus long hold-offs on request
    initial begin
        int hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (sink_hold_done != sink_hold_asks) begin
                sink_hold_done++;
                hold_left = SINK_HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_parity want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (parity_q.size() == 0) begin
                $error("unexpected parity transfer: parity_byte=%02h parity_last=%0b",
                       m_axis_tdata, m_axis_tlast);
                fail_cnt++;
            end else begin
                want = parity_q.pop_front();
                parity_cnt++;
                if (m_axis_tdata !== want.parity) begin
                    $error("parity_byte mismatch: expected %02h actual %02h",
                           want.parity, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("parity_last mismatch: expected %0b actual %0b",
                           want.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end

        // Count cycles with no transfer on any channel
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int         phase;
        int         phase_len;
        int         phase_bytes;
        int         blk_len;
        int         rand_bytes;
        logic [4:0] deg_pick;
        logic [7:0] b;
        logic       hold_phase;

        // Directed vectors. Fixed parity is used only where it is obvious:
        // a zero block on an empty remainder is all zero, and at degree 1
        // g(x) = x + 1, so the single parity byte is the XOR of the block.
        vecs = '{
            // degree 15 out of reset: zero byte on an empty remainder
            '{1'b0, 5'd0,  8'h00, 1'b1, 1'b1, 8'h00},
            '{1'b0, 5'd0,  8'hFF, 1'b0, 1'b0, 8'h00},
            '{1'b0, 5'd0,  8'h01, 1'b0, 1'b0, 8'h00},
            '{1'b0, 5'd0,  8'h80, 1'b1, 1'b0, 8'h00},
            // degree 0 clamps to 1
            '{1'b1, 5'd0,  8'h5A, 1'b1, 1'b1, 8'h5A},
            '{1'b0, 5'd0,  8'h3C, 1'b0, 1'b0, 8'h00},
            '{1'b0, 5'd0,  8'hFF, 1'b1, 1'b1, 8'hC3},
            '{1'b0, 5'd0,  8'h00, 1'b1, 1'b1, 8'h00},
            // leave a block open, then a degree write restarts it
            '{1'b0, 5'd0,  8'h77, 1'b0, 1'b0, 8'h00},
            // degree 31 saturates to the maximum
            '{1'b1, 5'd31, 8'hA5, 1'b0, 1'b0, 8'h00},
            '{1'b0, 5'd0,  8'hFF, 1'b0, 1'b0, 8'h00},
            '{1'b0, 5'd0,  8'h00, 1'b1, 1'b0, 8'h00},
            '{1'b0, 5'd0,  8'h00, 1'b1, 1'b1, 8'h00},
            '{1'b1, 5'd30, 8'h80, 1'b1, 1'b0, 8'h00},
            '{1'b1, 5'd2,  8'h01, 1'b1, 1'b0, 8'h00},
            '{1'b0, 5'd0,  8'hFE, 1'b0, 1'b0, 8'h00},
            '{1'b0, 5'd0,  8'hFF, 1'b1, 1'b0, 8'h00},
            '{1'b1, 5'd1,  8'hFF, 1'b1, 1'b1, 8'hFF},
            '{1'b1, 5'd15, 8'h12, 1'b1, 1'b0, 8'h00}
        };

        load_degree(5'(rse_pkg::RESET_DEGREE));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (vecs[k]) begin
            if (vecs[k].cfg_en) write_degree(vecs[k].cfg_val);
            push_byte(vecs[k].data, vecs[k].last, vecs[k].fixed, vecs[k].parity_fixed);
        end

        // Random phases: pick a degree, stream whole blocks of random bytes
        rand_bytes = 0;
        phase      = 0;
        while (rand_bytes < ITEMS) begin
            hold_phase = (phase == 4);
            case ($urandom_range(0, 9))
                0:       deg_pick = 5'd0;
                1:       deg_pick = 5'd31;
                2:       deg_pick = 5'd30;
                3:       deg_pick = 5'd1;
                default: deg_pick = 5'($urandom_range(1, MAXD));
            endcase
            // Degree 1 single-byte blocks fill the output side fastest
            if (hold_phase) deg_pick = 5'd1;
            write_degree(deg_pick);
            steady <= (phase == 2);
            if (hold_phase) sink_hold_asks++;

            phase_len   = $urandom_range(20, 60);
            phase_bytes = 0;
            while (phase_bytes < phase_len) begin
                if (hold_phase)                    blk_len = 1;
                else if ($urandom_range(0, 9) == 0) blk_len = $urandom_range(9, 40);
                else                               blk_len = $urandom_range(1, 8);
                for (int n = 0; n < blk_len; n++) begin
                    case ($urandom_range(0, 15))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    push_byte(b, n == blk_len - 1, 1'b0, 8'h00);
                end
                phase_bytes += blk_len;
                // Hold the sender until every parity byte so far has drained
                if ((phase == 1 && phase_bytes == blk_len) || $urandom_range(0, 19) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
            end
            rand_bytes += phase_bytes;

            // Sometimes leave a block half-sent across the next degree write
            if (rand_bytes < ITEMS && $urandom_range(0, 3) == 0) begin
                for (int n = $urandom_range(1, 4); n > 0; n--) begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 8'h00);
                    rand_bytes++;
                end
            end
            steady <= 1'b0;
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d data bytes in %0d blocks over %0d degree writes",
                 byte_cnt, block_cnt, cfg_cnt);
        $display("checked %0d parity bytes, %0d mismatches", parity_cnt, fail_cnt);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
